/* rtl/core/b64e_pkg.sv */
package b64e_pkg;

  // ASCII codes used by the encoder.
  localparam logic [6:0] CharPad   = 7'h3D;  // '='
  localparam logic [6:0] CharPlus  = 7'h2B;  // '+'
  localparam logic [6:0] CharSlash = 7'h2F;  // '/'
  localparam logic [6:0] CharUpA   = 7'h41;  // 'A'
  localparam logic [6:0] CharLowA  = 7'h61;  // 'a'
  localparam logic [6:0] CharZero  = 7'h30;  // '0'

  // Default depth of the group queue between front and back.
  localparam int unsigned QueueDepthDefault = 2;

  // Pad counts carried with a group.
  localparam logic [1:0] PadNone = 2'd0;
  localparam logic [1:0] PadOne  = 2'd1;
  localparam logic [1:0] PadTwo  = 2'd2;

  // One 24-bit group ready for character output.
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  npad;
    logic        fin;
  } group_t;

  // Map a 6-bit value onto the standard alphabet.
  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd26) begin
      c = CharUpA + {1'b0, v};
    end else if (v < 6'd52) begin
      c = CharLowA + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      c = CharZero + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      c = CharPlus;
    end else begin
      c = CharSlash;
    end
    return c;
  endfunction

endpackage

/* rtl/core/b64e_front.sv */
module b64e_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic            q_full,
  output logic            q_push,
  output b64e_pkg::group_t q_data
);
  import b64e_pkg::*;

  logic [15:0] pending;
  logic [1:0]  pending_count;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Build a group when a third byte arrives or the message ends.
  always_comb begin
    q_push = 1'b0;
    q_data = '0;
    q_data.fin = in_last;
    if (pending_count == 2'd2) begin
      q_push      = accept;
      q_data.bits = {pending, in_byte};
      q_data.npad = PadNone;
    end else if (in_last) begin
      q_push = accept;
      if (pending_count == 2'd0) begin
        q_data.bits = {in_byte, 16'h0000};
        q_data.npad = PadTwo;
      end else begin
        q_data.bits = {pending[7:0], in_byte, 8'h00};
        q_data.npad = PadOne;
      end
    end
  end

  // Hold bytes that do not yet complete a group.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 2'd0;
      pending       <= 16'h0000;
    end else if (accept) begin
      if (q_push) begin
        pending_count <= 2'd0;
        pending       <= 16'h0000;
      end else begin
        pending_count <= pending_count + 2'd1;
        pending       <= {pending[7:0], in_byte};
      end
    end
  end

endmodule

/* rtl/core/b64e_queue.sv */
module b64e_queue #(
  parameter int unsigned DEPTH = b64e_pkg::QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64e_pkg::group_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output b64e_pkg::group_t head_data
);
  import b64e_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  group_t            entries [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == CntW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/b64e_back.sv */
module b64e_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  b64e_pkg::group_t head_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [6:0]       out_char,
  output logic             out_group_end,
  output logic             out_message_end
);
  import b64e_pkg::*;

  logic [1:0] idx;
  logic [5:0] sextet;
  logic       is_pad;
  logic [6:0] char_next;
  logic       load;

  // The output register takes a new item when empty or being drained.
  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && (idx == 2'd3);

  // Pick the sextet for the current position and decide on padding.
  always_comb begin
    case (idx)
      2'd0:    sextet = head_data.bits[23:18];
      2'd1:    sextet = head_data.bits[17:12];
      2'd2:    sextet = head_data.bits[11:6];
      default: sextet = head_data.bits[5:0];
    endcase
    is_pad = ((idx == 2'd3) && (head_data.npad != PadNone)) ||
             ((idx == 2'd2) && (head_data.npad == PadTwo));
    char_next = is_pad ? CharPad : sextet_char(sextet);
  end

  // Character position within the group.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (load) begin
      idx <= idx + 2'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char        <= char_next;
      out_group_end   <= (idx == 2'd3);
      out_message_end <= (idx == 2'd3) && head_data.fin;
    end
  end

endmodule

/* rtl/core/base64_stream_encoder.sv */
// Streaming Base64 encoder with the standard alphabet and '=' padding.
// Input stream (s_*): one raw byte per item in s_tdata; s_tlast marks the
// last byte of a message. Output stream (m_*): one ASCII character per item
// in m_tdata[6:0]; m_tuser is high on the fourth character of each group and
// m_tlast on the final character of a message.
// Every third byte, or a byte with s_tlast, forms a 24-bit group that yields
// four characters; a short final group is zero-filled and ends in "=" or "==".
// The byte that completes a group is written into the group queue; its
// characters are then loaded one by one from the queue head into the
// output register. Throughput: the character stage emits one character per
// cycle while m_tready is high and pops a group with its fourth character.
// A group queue of QUEUE_DEPTH entries sits between the byte side and the
// character side, so the input keeps accepting while m_tready is low until
// that queue fills; then s_tready drops. Reset empties the queue, clears the
// pending bytes and drops m_tvalid.
module base64_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // final_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
  output logic       m_tuser,   // [0] group_end
  output logic       m_tlast    // message_end
);
  import b64e_pkg::*;

  group_t     push_data;
  group_t     head_data;
  logic       push;
  logic       full;
  logic       pop;
  logic       head_valid;
  logic [6:0] out_char;

  b64e_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .q_full   (full),
    .q_push   (push),
    .q_data   (push_data)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  b64e_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head_data       (head_data),
    .pop             (pop),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_char        (out_char),
    .out_group_end   (m_tuser),
    .out_message_end (m_tlast)
  );

  assign m_tdata = {1'b0, out_char};

endmodule
